>>> hw/rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, operation codes and the result type of the block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int SIZE_W    = 24;   // request size in bytes
  localparam int BLK_W     = 10;   // block index on the ports
  localparam int PCT_W     = 7;    // usage percent
  localparam int TBL_W     = 8;    // one table entry: run length or 0
  localparam int NEED_W    = 8;    // blocks in one allocation
  localparam int MAX_RUN   = 254;  // longest allocation in blocks
  localparam int PCT_SCALE = 100;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic             ok;
    logic [BLK_W-1:0] start_block;
    logic [PCT_W-1:0] usage_percent;
  } res_t;

endpackage

>>> hw/rtl/ffba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_in_if / ffba_out_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface ffba_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [ffba_pkg::SIZE_W-1:0] size_bytes;
  logic [ffba_pkg::BLK_W-1:0]  free_block;

  modport source (output valid, func, size_bytes, free_block, input ready);
  modport sink   (input valid, func, size_bytes, free_block, output ready);
endinterface

interface ffba_out_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [ffba_pkg::BLK_W-1:0] start_block;
  logic [ffba_pkg::PCT_W-1:0] usage_percent;

  modport source (output valid, ok, start_block, usage_percent, input ready);
  modport sink   (input valid, ok, start_block, usage_percent, output ready);
endinterface

>>> hw/rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a pool of fixed-size blocks with a result register.
// ----------------------------------------------------------------------------
// After reset the block table is cleared one entry per cycle, and no request
// is taken until that pass ends. Requests are handled one at a time. An
// allocate is accepted, its byte size is rounded to blocks, then the first-fit
// scan visits table entries (up to POOL_BLOCKS, jumps over allocations visit
// only their first entry), the blocks are marked one per cycle, the usage
// percent is computed and the word is handed to the result register when it
// is free. A free reads the entry, clears its blocks one per cycle and
// recomputes the usage percent; a free of a free block skips the clearing.
// Requests that fail their size or range check, an allocate beyond the free
// count and a scan that finds no run go straight to the answer. The table
// RAM with one write and one read port sets the pace: one entry read or
// written per cycle.
module first_fit_block_allocator #(
  parameter int POOL_BLOCKS = 1024,
  parameter int BLOCK_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ffba_in_if.sink    in_if,
  ffba_out_if.source out_if
);

  logic           res_valid;
  logic           res_ready;
  ffba_pkg::res_t res;
  logic           out_valid_r;
  ffba_pkg::res_t out_word_r;

  ffba_ctrl #(
    .POOL_BLOCKS (POOL_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result register, refilled in the cycle the old word leaves
  assign res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.ok            = out_word_r.ok;
  assign out_if.start_block   = out_word_r.start_block;
  assign out_if.usage_percent = out_word_r.usage_percent;

endmodule

>>> hw/rtl/ffba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/ffba_cdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_cdiv
// Division by a constant: reciprocal multiply, then one correction step.
// ----------------------------------------------------------------------------
module ffba_cdiv #(
  parameter int DIVISOR = 64,
  parameter int N_W     = 25,
  parameter int Q_W     = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  output logic           busy,
  output logic           done,
  output logic [Q_W-1:0] quot
);

  localparam int M_W = N_W + 1;
  localparam int P_W = N_W + M_W;
  // floor(2^N_W / DIVISOR): the estimate is the quotient or one below it
  localparam logic [M_W-1:0] RECIP = M_W'((longint'(1) << N_W) / longint'(DIVISOR));

  logic [N_W-1:0] num_r;
  logic [Q_W-1:0] est_r;
  logic [Q_W-1:0] quot_r;
  logic           fix_r;
  logic           busy_r;
  logic           done_r;
  logic [P_W-1:0] prod;
  logic [N_W-1:0] rem;

  assign prod = P_W'(num_r) * P_W'(RECIP);
  assign rem  = num_r - N_W'(est_r) * N_W'(DIVISOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      fix_r  <= 1'b0;
      num_r  <= '0;
      est_r  <= '0;
      quot_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        fix_r  <= 1'b0;
        num_r  <= num;
      end else if (busy_r && !fix_r) begin
        est_r <= prod[N_W +: Q_W];
        fix_r <= 1'b1;
      end else if (busy_r) begin
        // a whole divisor left over means the estimate is one short
        if (rem >= N_W'(DIVISOR)) begin
          quot_r <= est_r + Q_W'(1);
        end else begin
          quot_r <= est_r;
        end
        busy_r <= 1'b0;
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> hw/rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer around the block table: clear, first-fit scan, mark and free.
// ----------------------------------------------------------------------------
module ffba_ctrl #(
  parameter int POOL_BLOCKS = 1024,
  parameter int BLOCK_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  ffba_in_if.sink        in_if,
  output logic           res_valid,
  input  logic           res_ready,
  output ffba_pkg::res_t res
);

  localparam int AW     = $clog2(POOL_BLOCKS);
  localparam int FW     = $clog2(POOL_BLOCKS + ffba_pkg::MAX_RUN + 1);
  localparam int UW     = $clog2(POOL_BLOCKS + 1);
  localparam int XW     = (FW > ffba_pkg::BLK_W) ? FW : ffba_pkg::BLK_W;
  localparam int VW     = (UW > ffba_pkg::NEED_W) ? UW : ffba_pkg::NEED_W;
  localparam int NUM_W  = ffba_pkg::SIZE_W + 1;
  localparam int PN_W   = UW + ffba_pkg::PCT_W;
  localparam int MAX_BYTES = ffba_pkg::MAX_RUN * BLOCK_BYTES;
  localparam int NW     = ffba_pkg::NEED_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_NEED  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MARK  = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FCLR  = 4'd6;
  localparam logic [3:0] S_PCT   = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [3:0]                 state_r, state_nxt;
  logic [AW-1:0]              clr_r, clr_nxt;
  logic [FW-1:0]              fp_r, fp_nxt;
  logic [FW-1:0]              sp_r, sp_nxt;
  logic [NW-1:0]              need_r, need_nxt;
  logic [AW-1:0]              wp_r, wp_nxt;
  logic [NW-1:0]              cnt_r, cnt_nxt;
  logic [NW-1:0]              fcnt_r, fcnt_nxt;
  logic [UW-1:0]              used_r, used_nxt;
  logic [ffba_pkg::BLK_W-1:0] blk_r, blk_nxt;
  logic                       res_ok_r, res_ok_nxt;
  logic [ffba_pkg::BLK_W-1:0] res_start_r, res_start_nxt;

  logic                       ram_we;
  logic [AW-1:0]              ram_wa;
  logic [ffba_pkg::TBL_W-1:0] ram_wd;
  logic [AW-1:0]              ram_ra;
  logic [ffba_pkg::TBL_W-1:0] ram_rd;

  logic                       need_start, need_busy, need_done;
  logic [NW-1:0]              need_q;
  logic                       pct_start, pct_busy, pct_done;
  logic [ffba_pkg::PCT_W-1:0] pct_q;
  logic [PN_W-1:0]            pct_num;
  logic [FW-1:0]              run_len;

  ffba_ram #(
    .WIDTH (ffba_pkg::TBL_W),
    .DEPTH (POOL_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // blocks needed = ceil(size / BLOCK_BYTES)
  ffba_cdiv #(
    .DIVISOR (BLOCK_BYTES),
    .N_W     (NUM_W),
    .Q_W     (NW)
  ) u_need_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (need_start),
    .num   (NUM_W'(in_if.size_bytes) + NUM_W'(BLOCK_BYTES - 1)),
    .busy  (need_busy),
    .done  (need_done),
    .quot  (need_q)
  );

  // usage percent, kept up to date after every change of the used count
  ffba_cdiv #(
    .DIVISOR (POOL_BLOCKS),
    .N_W     (PN_W),
    .Q_W     (ffba_pkg::PCT_W)
  ) u_pct_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pct_start),
    .num   (pct_num),
    .busy  (pct_busy),
    .done  (pct_done),
    .quot  (pct_q)
  );

  assign pct_num = PN_W'(used_nxt) * PN_W'(ffba_pkg::PCT_SCALE);
  assign run_len = fp_r - sp_r + FW'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    fp_nxt        = fp_r;
    sp_nxt        = sp_r;
    need_nxt      = need_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    fcnt_nxt      = fcnt_r;
    used_nxt      = used_r;
    blk_nxt       = blk_r;
    res_ok_nxt    = res_ok_r;
    res_start_nxt = res_start_r;
    ram_we        = 1'b0;
    ram_wa        = wp_r;
    ram_wd        = '0;
    ram_ra        = '0;
    need_start    = 1'b0;
    pct_start     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        ram_wa  = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(POOL_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_if.valid) begin
          blk_nxt       = in_if.free_block;
          res_ok_nxt    = 1'b0;
          res_start_nxt = '0;
          if (in_if.func == ffba_pkg::FUNC_ALLOC) begin
            if (in_if.size_bytes == '0 ||
                in_if.size_bytes > ffba_pkg::SIZE_W'(MAX_BYTES)) begin
              state_nxt = S_RESP;
            end else begin
              need_start = 1'b1;
              state_nxt  = S_NEED;
            end
          end else begin
            if (XW'(in_if.free_block) >= XW'(POOL_BLOCKS)) begin
              state_nxt = S_RESP;
            end else begin
              ram_ra    = AW'(in_if.free_block);
              state_nxt = S_FRD;
            end
          end
        end
      end
      S_NEED: begin
        if (need_done) begin
          need_nxt = need_q;
          if (VW'(need_q) > VW'(POOL_BLOCKS) - VW'(used_r)) begin
            state_nxt = S_RESP;
          end else begin
            ram_ra    = '0;
            fp_nxt    = '0;
            sp_nxt    = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // ram_rd holds the entry at fp_r
        if (ram_rd == '0 && run_len == FW'(need_r)) begin
          wp_nxt    = AW'(sp_r);
          cnt_nxt   = need_r;
          state_nxt = S_MARK;
        end else begin
          if (ram_rd == '0) begin
            fp_nxt = fp_r + FW'(1);
          end else begin
            // jump over the allocation and restart the run after it
            fp_nxt = fp_r + FW'(ram_rd);
            sp_nxt = fp_r + FW'(ram_rd);
          end
          if (fp_nxt >= FW'(POOL_BLOCKS)) begin
            state_nxt = S_RESP;
          end else begin
            ram_ra = AW'(fp_nxt);
          end
        end
      end
      S_MARK: begin
        ram_we  = 1'b1;
        ram_wa  = wp_r;
        ram_wd  = ffba_pkg::TBL_W'(need_r);
        wp_nxt  = wp_r + AW'(1);
        cnt_nxt = cnt_r - NW'(1);
        if (cnt_r == NW'(1)) begin
          used_nxt      = UW'(VW'(used_r) + VW'(need_r));
          pct_start     = 1'b1;
          res_ok_nxt    = 1'b1;
          res_start_nxt = ffba_pkg::BLK_W'(sp_r);
          state_nxt     = S_PCT;
        end
      end
      S_FRD: begin
        fcnt_nxt   = NW'(ram_rd);
        res_ok_nxt = 1'b1;
        if (ram_rd == '0) begin
          state_nxt = S_RESP;
        end else begin
          wp_nxt    = AW'(blk_r);
          cnt_nxt   = NW'(ram_rd);
          state_nxt = S_FCLR;
        end
      end
      S_FCLR: begin
        ram_we  = 1'b1;
        ram_wa  = wp_r;
        wp_nxt  = wp_r + AW'(1);
        cnt_nxt = cnt_r - NW'(1);
        // stop at the stored count or at the pool end, whichever comes first
        if (cnt_r == NW'(1) || wp_r == AW'(POOL_BLOCKS - 1)) begin
          if (VW'(used_r) >= VW'(fcnt_r)) begin
            used_nxt = UW'(VW'(used_r) - VW'(fcnt_r));
          end else begin
            used_nxt = '0;
          end
          pct_start = 1'b1;
          state_nxt = S_PCT;
        end
      end
      S_PCT: begin
        if (pct_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fp_r        <= fp_nxt;
    sp_r        <= sp_nxt;
    need_r      <= need_nxt;
    wp_r        <= wp_nxt;
    cnt_r       <= cnt_nxt;
    fcnt_r      <= fcnt_nxt;
    blk_r       <= blk_nxt;
    res_ok_r    <= res_ok_nxt;
    res_start_r <= res_start_nxt;
  end

  assign in_if.ready       = (state_r == S_IDLE);
  assign res_valid         = (state_r == S_RESP);
  assign res.ok            = res_ok_r;
  assign res.start_block   = res_start_r;
  assign res.usage_percent = pct_q;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_if.ready)
    else $error("request taken during table clear");

  a_used_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(POOL_BLOCKS))
    else $error("used count beyond pool size");

  a_res_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!pct_busy && !need_busy))
    else $error("result offered while a divide is running");

  a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.ok) |-> (res.start_block == '0))
    else $error("failed request carries a start block");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !ram_we)
    else $error("table write during scan");

endmodule

>>> tb/sv/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking bench for the first-fit block allocator. A short directed
// sequence walks the pool from empty to full and back through the error
// paths, then random allocate/free traffic runs under bursty input and a
// stalling receiver. Every result word is compared against its pinned result
// or against a shadow copy of the block table kept in the bench.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;

  localparam int          POOL_BLOCKS  = 1024;
  localparam int          BLOCK_BYTES  = 64;
  localparam int          DIR_ROWS     = 25;
  localparam int          RANDOM_WORDS = 555;
  localparam int          LONG_HOLD    = 400;
  localparam int          DRAIN_CYCLES = 1600;
  localparam longint      LIMIT_NS     = 70_000_000;

  typedef struct packed {
    logic                        func;
    logic [ffba_pkg::SIZE_W-1:0] size;
    logic [ffba_pkg::BLK_W-1:0]  blk;
    logic                        pinned;
    ffba_pkg::res_t              want;
  } plan_row_t;

  typedef struct packed {
    logic           pinned;
    ffba_pkg::res_t want;
  } word_tag_t;

  logic clk;
  logic rst_n;

  ffba_in_if  in_bus ();
  ffba_out_if out_bus ();

  first_fit_block_allocator #(
    .POOL_BLOCKS(POOL_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  // pinned rows carry a result that follows directly from the sequence above
  plan_row_t directed_plan [DIR_ROWS] = '{
    '{ffba_pkg::FUNC_ALLOC, 24'd0,      10'd0,    1'b1, '{1'b0, 10'd0,    7'd0}},
    '{ffba_pkg::FUNC_ALLOC, 24'd1,      10'd0,    1'b1, '{1'b1, 10'd0,    7'd0}},
    '{ffba_pkg::FUNC_ALLOC, 24'hFFFFFF, 10'd0,    1'b1, '{1'b0, 10'd0,    7'd0}},
    '{ffba_pkg::FUNC_ALLOC, 24'd16256,  10'd0,    1'b1, '{1'b1, 10'd1,    7'd24}},
    '{ffba_pkg::FUNC_ALLOC, 24'd16257,  10'd0,    1'b1, '{1'b0, 10'd0,    7'd24}},
    '{ffba_pkg::FUNC_ALLOC, 24'd16256,  10'd0,    1'b0, '0},
    '{ffba_pkg::FUNC_ALLOC, 24'd16256,  10'd0,    1'b0, '0},
    '{ffba_pkg::FUNC_ALLOC, 24'd16256,  10'd0,    1'b0, '0},
    '{ffba_pkg::FUNC_ALLOC, 24'd512,    10'd0,    1'b1, '{1'b0, 10'd0,    7'd99}},
    '{ffba_pkg::FUNC_ALLOC, 24'd448,    10'd0,    1'b1, '{1'b1, 10'd1017, 7'd100}},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd1023, 1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd0,    1'b0, '0},
    '{ffba_pkg::FUNC_ALLOC, 24'd128,    10'd0,    1'b1, '{1'b0, 10'd0,    7'd99}},
    '{ffba_pkg::FUNC_ALLOC, 24'd1,      10'd0,    1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd255,  1'b0, '0},
    '{ffba_pkg::FUNC_ALLOC, 24'd16256,  10'd0,    1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd1,    1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd509,  1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd763,  1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd255,  1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd1017, 1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd0,    1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'd0,      10'd0,    1'b1, '{1'b1, 10'd0,    7'd0}},
    '{ffba_pkg::FUNC_ALLOC, 24'd63,     10'd1023, 1'b0, '0},
    '{ffba_pkg::FUNC_FREE,  24'hFFFFFF, 10'd0,    1'b0, '0}
  };

  logic [ffba_pkg::TBL_W-1:0] shadow_table [POOL_BLOCKS];
  int unsigned                shadow_used;
  int unsigned                live_starts [$];
  word_tag_t                  sent_tags [$];
  ffba_pkg::res_t             expected_results [$];
  int                         mismatches;
  int                         results_seen;
  word_tag_t                  accept_tag;
  ffba_pkg::res_t             accept_res;
  ffba_pkg::res_t             check_want;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("first_fit_block_allocator verification failed");
    $finish;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // one allocate or free against the shadow pool, returns the result word
  function automatic ffba_pkg::res_t pool_step(logic func,
                                               logic [ffba_pkg::SIZE_W-1:0] size,
                                               logic [ffba_pkg::BLK_W-1:0] blk);
    ffba_pkg::res_t r;
    int unsigned    need, sp, fp, cnt, i;
    bit             found;
    r     = '0;
    found = 1'b0;
    if (func == ffba_pkg::FUNC_ALLOC) begin
      need = (32'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      if (need != 0 && need <= ffba_pkg::MAX_RUN && need <= POOL_BLOCKS - shadow_used) begin
        sp = 0;
        fp = 0;
        while (fp < POOL_BLOCKS && !found) begin
          if (shadow_table[fp] == '0) begin
            if (fp - sp + 1 == need) found = 1'b1;
            else fp++;
          end else begin
            // hop over the allocation by its stored length
            fp = fp + shadow_table[fp];
            sp = fp;
          end
        end
        if (found) begin
          for (i = sp; i <= fp; i++) shadow_table[i] = ffba_pkg::TBL_W'(need);
          shadow_used += need;
          r.ok          = 1'b1;
          r.start_block = ffba_pkg::BLK_W'(sp);
          live_starts.push_back(sp);
        end
      end
    end else if (32'(blk) < POOL_BLOCKS) begin
      cnt = shadow_table[blk];
      for (i = 0; i < cnt && 32'(blk) + i < POOL_BLOCKS; i++) shadow_table[32'(blk) + i] = '0;
      shadow_used = (shadow_used >= cnt) ? shadow_used - cnt : 0;
      // drop every tracked start inside the cleared span
      for (i = live_starts.size(); i > 0; i--) begin
        if (live_starts[i-1] >= 32'(blk) && live_starts[i-1] < 32'(blk) + cnt)
          live_starts.delete(i-1);
      end
      r.ok = 1'b1;
    end
    r.usage_percent = ffba_pkg::PCT_W'(shadow_used * ffba_pkg::PCT_SCALE / POOL_BLOCKS);
    return r;
  endfunction

  // accepted request words
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      accept_tag = sent_tags.pop_front();
      accept_res = pool_step(in_bus.func, in_bus.size_bytes, in_bus.free_block);
      expected_results.push_back(accept_tag.pinned ? accept_tag.want : accept_res);
    end
  end

  // result words
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word, start_block", out_bus.start_block, 0);
      end else begin
        check_want = expected_results.pop_front();
        if (out_bus.ok !== check_want.ok)
          report_mismatch("ok", out_bus.ok, check_want.ok);
        if (out_bus.start_block !== check_want.start_block)
          report_mismatch("start_block", out_bus.start_block, check_want.start_block);
        if (out_bus.usage_percent !== check_want.usage_percent)
          report_mismatch("usage_percent", out_bus.usage_percent, check_want.usage_percent);
      end
    end
  end

  // receiver: stretches of different stall patterns, plus one long hold-off
  initial begin
    int      mode, span, k;
    bit      held;
    logic [7:0] pat;
    out_bus.ready = 1'b0;
    held = 1'b0;
    pat  = 8'b1011_0110;
    k    = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        k++;
        if (!held && results_seen >= 150) begin
          out_bus.ready <= 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
          held = 1'b1;
        end
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 99) < 70);
          2: out_bus.ready <= pat[3'(k % 8)];
          default: out_bus.ready <= ($urandom_range(0, 99) < 25);
        endcase
      end
    end
  end

  task automatic offer_word(logic func, logic [ffba_pkg::SIZE_W-1:0] size,
                            logic [ffba_pkg::BLK_W-1:0] blk,
                            logic pinned, ffba_pkg::res_t want);
    word_tag_t tag;
    tag.pinned = pinned;
    tag.want   = want;
    sent_tags.push_back(tag);
    @(negedge clk);
    in_bus.valid      <= 1'b1;
    in_bus.func       <= func;
    in_bus.size_bytes <= size;
    in_bus.free_block <= blk;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic sender_gap(int n);
    repeat (n) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
  endtask

  task automatic wait_all_results();
    while (expected_results.size() != 0 || sent_tags.size() != 0) @(posedge clk);
  endtask

  task automatic pick_request(int alloc_pct, output logic func,
                              output logic [ffba_pkg::SIZE_W-1:0] size,
                              output logic [ffba_pkg::BLK_W-1:0] blk);
    int          sel;
    int unsigned bytes;
    sel = $urandom_range(0, 99);
    blk = ffba_pkg::BLK_W'($urandom);
    if ($urandom_range(0, 99) < alloc_pct) begin
      func = ffba_pkg::FUNC_ALLOC;
      if (sel < 70)
        bytes = ($urandom_range(1, 16) - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
      else if (sel < 85)
        bytes = ($urandom_range(17, ffba_pkg::MAX_RUN) - 1) * BLOCK_BYTES
                + $urandom_range(1, BLOCK_BYTES);
      else if (sel < 90)
        bytes = 0;
      else if (sel < 95)
        bytes = $urandom_range(ffba_pkg::MAX_RUN * BLOCK_BYTES + 1, 24'hFFFFFF);
      else
        bytes = $urandom;
      size = ffba_pkg::SIZE_W'(bytes);
    end else begin
      func = ffba_pkg::FUNC_FREE;
      size = ffba_pkg::SIZE_W'($urandom);
      // mostly real allocations, the rest lands anywhere
      if (sel < 75 && live_starts.size() != 0)
        blk = ffba_pkg::BLK_W'(live_starts[$urandom_range(0, live_starts.size() - 1)]);
    end
  endtask

  initial begin
    int                          n, burst_left, alloc_pct;
    logic                        func;
    logic [ffba_pkg::SIZE_W-1:0] size;
    logic [ffba_pkg::BLK_W-1:0]  blk;
    for (n = 0; n < POOL_BLOCKS; n++) shadow_table[n] = '0;
    shadow_used       = 0;
    mismatches        = 0;
    results_seen      = 0;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.func       = ffba_pkg::FUNC_ALLOC;
    in_bus.size_bytes = '0;
    in_bus.free_block = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIR_ROWS; n++) begin
      offer_word(directed_plan[n].func, directed_plan[n].size, directed_plan[n].blk,
                 directed_plan[n].pinned, directed_plan[n].want);
      if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 25));
    end
    sender_gap(1);
    wait_all_results();

    burst_left = 0;
    alloc_pct  = 60;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: alloc_pct = 30;
          1: alloc_pct = 60;
          default: alloc_pct = 85;
        endcase
      end
      // one pause with nothing in flight
      if (n == 400) begin
        sender_gap(1);
        wait_all_results();
      end
      if (burst_left == 0) begin
        sender_gap($urandom_range(1, 25));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      pick_request(alloc_pct, func, size, blk);
      offer_word(func, size, blk, 1'b0, '0);
    end
    sender_gap(1);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("first_fit_block_allocator verification clean");
    else
      $display("first_fit_block_allocator verification failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_if.sv
hw/rtl/ffba_ram.sv
hw/rtl/ffba_cdiv.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/first_fit_block_allocator.sv
tb/sv/tb_first_fit_block_allocator.sv
